@@ sv/dpm_pkg.sv @@
// Shared constants and types for the double precision multiplier.
package dpm_pkg;
    localparam int FRAC_BITS = 52;
    localparam int EXP_BITS  = 11;
    localparam int SIG_BITS  = FRAC_BITS + 1;
    localparam int EXP_BIAS  = 1023;
    localparam int EXP_MAX   = 2046;
    localparam int HALF_BITS = 27;
    localparam int DEF_STAGES = 4;

    typedef struct packed {
        logic                 sign;
        logic [EXP_BITS+1:0]  exp_sum;
    } dpm_side_t;
endpackage

@@ sv/double_precision_multiplier_core.sv @@
// Top level of the truncating double precision multiplier.
// Registers from input transfer to result: input, partial product, sum and output, in that order.
// Throughput: one operand pair per cycle while the output is not stalled.
// The whole pipeline holds while the output is stalled and valid.
// Reset clears all valid bits; payload registers are not reset.
module double_precision_multiplier_core
    import dpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] product,
    output logic        range_error
);
    logic                  advance;
    logic                  in_valid_reg;
    logic [SIG_BITS-1:0]   sig_a_reg;
    logic [SIG_BITS-1:0]   sig_b_reg;
    dpm_side_t             side_reg;
    logic                  m_valid;
    logic [2*SIG_BITS-1:0] m_prod;
    dpm_side_t             m_side;
    logic                  out_valid_reg;
    logic [63:0]           product_reg;
    logic                  range_error_reg;
    logic [EXP_BITS+1:0]   exp_next;
    logic [FRAC_BITS-1:0]  frac_next;
    logic                  bad_next;

    // A bubble in the output slot may always be filled.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= in_valid;
            out_valid_reg <= m_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sig_a_reg <= {1'b1, operand_a[FRAC_BITS-1:0]};
            sig_b_reg <= {1'b1, operand_b[FRAC_BITS-1:0]};
            side_reg.sign <= operand_a[63] ^ operand_b[63];
            side_reg.exp_sum <= {2'b00, operand_a[62:FRAC_BITS]}
                              + {2'b00, operand_b[62:FRAC_BITS]}
                              - (EXP_BITS+2)'(EXP_BIAS);
        end
    end

    dpm_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid_reg),
        .sig_a    (sig_a_reg),
        .sig_b    (sig_b_reg),
        .side_in  (side_reg),
        .out_valid(m_valid),
        .prod     (m_prod),
        .side_out (m_side)
    );

    // The exponent sum is kept as a 13-bit two's complement value.
    always_comb
    begin
        exp_next = m_side.exp_sum + {{(EXP_BITS+1){1'b0}}, m_prod[2*SIG_BITS-1]};
        if (m_prod[2*SIG_BITS-1])
            frac_next = m_prod[2*SIG_BITS-2:SIG_BITS];
        else
            frac_next = m_prod[2*SIG_BITS-3:SIG_BITS-1];
        bad_next = exp_next[EXP_BITS+1] || (exp_next == '0)
                   || (exp_next > (EXP_BITS+2)'(EXP_MAX));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            range_error_reg <= bad_next;
            product_reg <= bad_next ? 64'd0
                         : {m_side.sign, exp_next[EXP_BITS-1:0], frac_next};
        end
    end

    assign out_valid   = out_valid_reg;
    assign product     = product_reg;
    assign range_error = range_error_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> product == 64'd0)
        else $error("range error with nonzero product");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product))
        else $error("stalled result changed");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");
endmodule

@@ sv/dpm_mult.sv @@
// Pipelined 53x53 significand multiplier built from partial products of 27-bit and 26-bit halves.
module dpm_mult
    import dpm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic [SIG_BITS-1:0]       sig_a,
    input  logic [SIG_BITS-1:0]       sig_b,
    input  dpm_side_t                 side_in,
    output logic                      out_valid,
    output logic [2*SIG_BITS-1:0]     prod,
    output dpm_side_t                 side_out
);
    localparam int HI_BITS = SIG_BITS - HALF_BITS;

    logic                        s1_valid_reg;
    logic [2*HALF_BITS-1:0]      p00_reg;
    logic [HALF_BITS+HI_BITS-1:0] p01_reg;
    logic [HALF_BITS+HI_BITS-1:0] p10_reg;
    logic [2*HI_BITS-1:0]        p11_reg;
    dpm_side_t                   s1_side_reg;

    logic                        s2_valid_reg;
    logic [2*SIG_BITS-1:0]       prod_reg;
    dpm_side_t                   s2_side_reg;

    logic [2*SIG_BITS-1:0]       sum_next;

    always_comb
    begin
        sum_next = {{(2*SIG_BITS-2*HALF_BITS){1'b0}}, p00_reg}
                 + ({{(2*SIG_BITS-HALF_BITS-HI_BITS){1'b0}}, p01_reg} << HALF_BITS)
                 + ({{(2*SIG_BITS-HALF_BITS-HI_BITS){1'b0}}, p10_reg} << HALF_BITS)
                 + ({{(2*SIG_BITS-2*HI_BITS){1'b0}}, p11_reg} << (2*HALF_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p00_reg     <= sig_a[HALF_BITS-1:0] * sig_b[HALF_BITS-1:0];
            p01_reg     <= sig_a[HALF_BITS-1:0] * sig_b[SIG_BITS-1:HALF_BITS];
            p10_reg     <= sig_a[SIG_BITS-1:HALF_BITS] * sig_b[HALF_BITS-1:0];
            p11_reg     <= sig_a[SIG_BITS-1:HALF_BITS] * sig_b[SIG_BITS-1:HALF_BITS];
            s1_side_reg <= side_in;
            prod_reg    <= sum_next;
            s2_side_reg <= s1_side_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign prod      = prod_reg;
    assign side_out  = s2_side_reg;
endmodule
